@@ src/ocvs_pkg.sv @@
// package: types, constants and helpers for the offload credit victim scheduler
`default_nettype none
package ocvs_pkg;

	localparam int NUM_RANKS = 8;
	localparam int RW = 3;
	localparam int MW = 6;
	localparam int VW = 31;

	localparam logic [RW-1:0] RANK_LAST = 3'(NUM_RANKS - 1);

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0,
		OP_WAIT = 3'd1,
		OP_UPDATE = 3'd2,
		OP_EMERG = 3'd3,
		OP_SELECT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REG_OWN = 2'd0,
		REG_THR = 2'd1,
		REG_MINQ = 2'd2,
		REG_UEN = 2'd3
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_CRIT,
		ST_SUM,
		ST_APPLY,
		ST_HALVE,
		ST_RELOAD,
		ST_SEL,
		ST_OUT
	} state_t;

	// controller commands to the datapath
	typedef struct packed {
		logic capture;
		logic do_simple;
		logic scan_clear;
		logic scan_step;
		logic crit_step;
		logic sum_step;
		logic apply;
		logic halve;
		logic reload;
		logic sel_step;
		logic finish_upd;
		logic finish_sel;
	} cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic scan_last;
		logic idx_last;
		logic crit_done;
		logic sel_done;
		logic need_halve;
	} sts_t;

endpackage
`default_nettype wire

@@ src/ocvs_ctrl.sv @@
// controller state machine sequencing update and select requests
`default_nettype none
module ocvs_ctrl import ocvs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [2:0] op,
	input wire logic update_enable,
	input wire logic out_stall,
	input wire sts_t sts,
	output logic in_stall,
	output logic out_valid,
	output cmd_t cmd
);

	state_t state_q, state_nx;
	logic out_valid_q;
	logic take;

	assign take = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (op == OP_UPDATE && update_enable) state_nx = ST_SCAN;
					else if (op == OP_SELECT) state_nx = ST_SEL;
				end
			end
			ST_SCAN: if (sts.scan_last) state_nx = ST_SCAN_LAST;
			ST_SCAN_LAST: state_nx = ST_CRIT;
			ST_CRIT: if (sts.crit_done) state_nx = ST_SUM;
			ST_SUM: if (sts.idx_last) state_nx = ST_APPLY;
			ST_APPLY: state_nx = sts.need_halve ? ST_HALVE : ST_RELOAD;
			ST_HALVE: state_nx = ST_RELOAD;
			ST_RELOAD: state_nx = ST_OUT;
			ST_SEL: if (sts.sel_done) state_nx = ST_OUT;
			ST_OUT: if (!(out_valid_q && out_stall)) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = take;
				cmd.do_simple = take;
				cmd.scan_clear = take;
			end
			ST_SCAN: cmd.scan_step = 1'b1;
			ST_SCAN_LAST: cmd.scan_step = 1'b1;
			ST_CRIT: cmd.crit_step = 1'b1;
			ST_SUM: cmd.sum_step = 1'b1;
			ST_APPLY: cmd.apply = 1'b1;
			ST_HALVE: cmd.halve = 1'b1;
			ST_RELOAD: begin
				cmd.reload = 1'b1;
				cmd.finish_upd = 1'b1;
			end
			ST_SEL: begin
				cmd.sel_step = !sts.sel_done;
				cmd.finish_sel = sts.sel_done;
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE && take && !((op == OP_UPDATE && update_enable)
					|| op == OP_SELECT))
				out_valid_q <= 1'b1;
			else if (state_q == ST_OUT && !(out_valid_q && out_stall))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// result never overwritten while held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall) else $error("accept while result held");
	// busy machine never takes a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("accept while busy");
	// a result follows the output state
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && !out_stall |=> out_valid) else $error("result lost");

endmodule
`default_nettype wire

@@ src/ocvs_dp.sv @@
// datapath: rank tables, wait matrix, scans and target arithmetic
`default_nettype none
module ocvs_dp import ocvs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	input wire logic [2:0] op,
	input wire logic [2:0] rank_first,
	input wire logic [2:0] rank_second,
	input wire logic [30:0] amount,
	input wire logic local_is_victim,
	input wire logic [7:0] blacklist_mask,
	input wire logic [15:0] queued_jobs,
	input wire logic [RW-1:0] own_rank,
	input wire logic [30:0] wait_threshold,
	input wire logic [15:0] min_queued_jobs,
	input wire logic update_enable,
	input wire logic out_taken,
	output sts_t sts,
	output logic [2:0] victim_rank,
	output logic offload_granted,
	output logic [2:0] critical_rank,
	output logic critical_valid,
	output logic [2:0] optimal_rank,
	output logic optimal_valid
);

	// wait matrix memory with registered read
	logic [VW-1:0] wmem [0:NUM_RANKS*NUM_RANKS-1];
	logic [VW-1:0] wrd_q;
	logic [MW:0] scan_q;
	logic [MW-1:0] rd_idx_q;

	logic [VW-1:0] load_q [0:NUM_RANKS-1];
	logic signed [31:0] tgt_q [0:NUM_RANKS-1];
	logic signed [31:0] crd_q [0:NUM_RANKS-1];
	logic [RW-1:0] rr_q;

	logic [NUM_RANKS-1:0] waits_q, awaited_q;
	logic [31:0] longest_q;
	logic opt_ok_q, crit_ok_q;
	logic [RW-1:0] opt_q, crit_q, idx_q;
	logic crit_done_q;
	logic signed [35:0] c_q;
	logic signed [35:0] s_q;
	logic [RW:0] sel_cnt_q;
	logic sel_found_q;
	logic [RW-1:0] victim_q;
	logic [15:0] queued_q;
	logic [7:0] mask_q;
	logic vic_q;

	logic [2:0] vr_q, cr_q, orr_q;
	logic og_q, cv_q, ov_q;

	logic [RW-1:0] rowi, coli;
	logic black;
	logic signed [35:0] o_w, s_w;
	logic signed [35:0] half_w;

	assign rowi = rd_idx_q[MW-1:RW];
	assign coli = rd_idx_q[RW-1:0];
	assign black = mask_q[rowi];

	// memory write and read
	always_ff @(posedge clk) begin
		if (cmd.do_simple && op == OP_WAIT)
			wmem[{rank_first, rank_second}] <= amount;
		wrd_q <= wmem[scan_q[MW-1:0]];
	end

	assign o_w = 36'(signed'({1'b0, load_q[opt_q]})) + 36'(tgt_q[opt_q]);
	assign s_w = 36'(tgt_q[opt_q]) * 36'sd2 + (c_q - o_w);
	assign half_w = (s_q + 36'(signed'({1'b0, s_q[35]}))) >>> 1;

	// wait matrix valid bits: entries cleared at reset read as zero
	logic [NUM_RANKS*NUM_RANKS-1:0] wvalid_q;
	logic [VW-1:0] wval;
	assign wval = wvalid_q[rd_idx_q] ? wrd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			rr_q <= '0;
			for (int i = 0; i < NUM_RANKS; i++) begin
				load_q[i] <= '0;
				tgt_q[i] <= '0;
				crd_q[i] <= '0;
			end
			crit_done_q <= 1'b0;
			sel_found_q <= 1'b0;
		end else begin
			if (cmd.do_simple) begin
				unique case (op)
					OP_LOAD: load_q[rank_first] <= amount;
					OP_WAIT: wvalid_q[{rank_first, rank_second}] <= 1'b1;
					OP_EMERG: begin
						if (tgt_q[rank_first] != 32'sh8000_0000) begin
							tgt_q[rank_first] <= tgt_q[rank_first] - 32'sd1;
							crd_q[rank_first] <= tgt_q[rank_first] - 32'sd1;
						end else crd_q[rank_first] <= tgt_q[rank_first];
					end
					default: ;
				endcase
			end
			if (cmd.capture) begin
				crit_done_q <= 1'b0;
				sel_found_q <= 1'b0;
			end
			// critical search, one rank a cycle
			if (cmd.crit_step && !crit_done_q) begin
				if (idx_q == RANK_LAST) crit_done_q <= 1'b1;
			end
			if (cmd.apply) begin
				if (crit_ok_q && own_rank == crit_q && !(opt_ok_q && crit_q == opt_q)) begin
					;
				end else if (crit_ok_q && tgt_q[crit_q] > 32'sd0) begin
					tgt_q[crit_q] <= tgt_q[crit_q] - 32'sd1;
				end
			end
			if (cmd.halve) begin
				if (half_w > 36'sh0_7FFF_FFFF) tgt_q[opt_q] <= 32'sh7FFF_FFFF;
				else if (half_w < -36'sh0_8000_0000) tgt_q[opt_q] <= 32'sh8000_0000;
				else tgt_q[opt_q] <= half_w[31:0];
			end
			if (cmd.reload)
				for (int i = 0; i < NUM_RANKS; i++)
					if (RW'(i) != own_rank) crd_q[i] <= tgt_q[i];
			// select: one credit per cycle
			if (cmd.sel_step && !sel_found_q) begin
				if (rr_q != own_rank && crd_q[rr_q] > 32'sd0) begin
					crd_q[rr_q] <= crd_q[rr_q] - 32'sd1;
					sel_found_q <= 1'b1;
				end else crd_q[rr_q] <= '0;
				rr_q <= rr_q + RW'(1);
			end
		end
	end

	// scan, search and sum registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			vic_q <= local_is_victim;
			mask_q <= blacklist_mask;
			queued_q <= queued_jobs;
			waits_q <= '0;
			awaited_q <= '0;
			longest_q <= '1;
			opt_ok_q <= 1'b0;
			crit_ok_q <= 1'b0;
			opt_q <= '0;
			crit_q <= '0;
			idx_q <= '0;
			c_q <= '0;
			sel_cnt_q <= '0;
			victim_q <= own_rank;
		end
		if (cmd.scan_clear)
			scan_q <= '0;
		else if (cmd.scan_step) begin
			rd_idx_q <= scan_q[MW-1:0];
			scan_q <= scan_q + 1'b1;
		end
		if (cmd.scan_step && scan_q != '0) begin
			if ((longest_q[31] || {1'b0, wval} > longest_q) && !black) begin
				longest_q <= {1'b0, wval};
				opt_q <= rowi;
				opt_ok_q <= 1'b1;
			end
			if (wval > wait_threshold) begin
				awaited_q[coli] <= 1'b1;
				waits_q[rowi] <= 1'b1;
			end
		end
		if (cmd.crit_step && !crit_done_q) begin
			if (!crit_ok_q && !waits_q[idx_q] && awaited_q[idx_q]) begin
				crit_ok_q <= 1'b1;
				crit_q <= idx_q;
			end
			idx_q <= idx_q + RW'(1);
			if (idx_q == RANK_LAST) c_q <= 36'(signed'({1'b0, load_q[crit_ok_q ||
				(!waits_q[idx_q] && awaited_q[idx_q]) ? (crit_ok_q ? crit_q : idx_q)
				: '0]}));
		end
		if (cmd.sum_step) begin
			c_q <= c_q - 36'(tgt_q[idx_q]);
			idx_q <= idx_q + RW'(1);
		end
		if (cmd.apply)
			s_q <= s_w;
		if (cmd.sel_step) begin
			sel_cnt_q <= sel_cnt_q + 1'b1;
			if (!sel_found_q && rr_q != own_rank && crd_q[rr_q] > 32'sd0)
				victim_q <= rr_q;
		end
	end

	assign sts.scan_last = scan_q == (MW+1)'(NUM_RANKS*NUM_RANKS);
	assign sts.idx_last = idx_q == RANK_LAST;
	assign sts.crit_done = crit_done_q;
	assign sts.need_halve = crit_ok_q && own_rank == crit_q && opt_ok_q
		&& crit_q != opt_q && !vic_q;
	assign sts.sel_done = sel_found_q || sel_cnt_q == (RW+1)'(NUM_RANKS);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.do_simple) begin
			vr_q <= own_rank;
			og_q <= 1'b0;
			cr_q <= '0;
			cv_q <= 1'b0;
			orr_q <= '0;
			ov_q <= 1'b0;
		end
		if (cmd.finish_upd) begin
			cr_q <= crit_ok_q ? crit_q : '0;
			cv_q <= crit_ok_q;
			orr_q <= opt_ok_q ? opt_q : '0;
			ov_q <= opt_ok_q;
		end
		if (cmd.finish_sel) begin
			if (queued_q < min_queued_jobs) begin
				vr_q <= own_rank;
				og_q <= 1'b0;
			end else begin
				vr_q <= victim_q;
				og_q <= victim_q != own_rank;
			end
		end
	end

	assign victim_rank = vr_q;
	assign offload_granted = og_q;
	assign critical_rank = cr_q;
	assign critical_valid = cv_q;
	assign optimal_rank = orr_q;
	assign optimal_valid = ov_q;

	// a grant always names a foreign rank
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_taken && offload_granted |-> victim_rank != own_rank)
		else $error("grant to own rank");
	// update flags only with update enabled
	a_upd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_upd |-> update_enable) else $error("update while disabled");
	// credits never consumed below zero by a select
	a_crd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sel_step && !sel_found_q && crd_q[rr_q] > 32'sd0 && rr_q != own_rank
		|=> crd_q[$past(rr_q)] >= 32'sd0) else $error("credit underflow");

endmodule
`default_nettype wire

@@ src/offload_credit_victim_scheduler_core.sv @@
// top level: configuration registers, controller and datapath
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall   | op, ranks, amount, victim flag, mask, jobs
//  out     | output    | out_valid / out_stall | victim, critical and optimal ranks
//  apb     | config    | psel/penable/pready   | own rank, threshold, min jobs, enable
// load, wait entry and emergency requests, and updates while disabled: result valid in the
// cycle after acceptance; an enabled update scans the wait matrix on one memory port,
// drains the read, runs the critical search and the target sum, then passes the apply,
// halve (only when a target is halved), reload and result states
// a select walks up to 8 credits, one a cycle
// one request is in flight at a time; reset empties the tables at once;
// a stalled result holds input off
`default_nettype none
module offload_credit_victim_scheduler_core import ocvs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] op,
	input wire logic [2:0] rank_first,
	input wire logic [2:0] rank_second,
	input wire logic [30:0] amount,
	input wire logic local_is_victim,
	input wire logic [7:0] blacklist_mask,
	input wire logic [15:0] queued_jobs,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] victim_rank,
	output logic offload_granted,
	output logic [2:0] critical_rank,
	output logic critical_valid,
	output logic [2:0] optimal_rank,
	output logic optimal_valid,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [RW-1:0] own_q;
	logic [30:0] thr_q;
	logic [15:0] minq_q;
	logic uen_q;
	cmd_t cmd;
	sts_t sts;
	reg_t ra;

	assign pready = 1'b1;
	assign ra = reg_t'(paddr[3:2]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
			thr_q <= 31'd20000;
			minq_q <= '0;
			uen_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			unique case (ra)
				REG_OWN: own_q <= pwdata[RW-1:0];
				REG_THR: thr_q <= pwdata[30:0];
				REG_MINQ: minq_q <= pwdata[15:0];
				REG_UEN: uen_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (ra)
				REG_OWN: prdata = {29'd0, own_q};
				REG_THR: prdata = {1'b0, thr_q};
				REG_MINQ: prdata = {16'd0, minq_q};
				REG_UEN: prdata = {31'd0, uen_q};
				default: prdata = '0;
			endcase
		end
	end

	ocvs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .op(op),
		.update_enable(uen_q), .out_stall(out_stall), .sts(sts),
		.in_stall(in_stall), .out_valid(out_valid), .cmd(cmd)
	);

	ocvs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .op(op), .rank_first(rank_first),
		.rank_second(rank_second), .amount(amount), .local_is_victim(local_is_victim),
		.blacklist_mask(blacklist_mask), .queued_jobs(queued_jobs), .own_rank(own_q),
		.wait_threshold(thr_q), .min_queued_jobs(minq_q), .update_enable(uen_q),
		.out_taken(out_valid && !out_stall), .sts(sts),
		.victim_rank(victim_rank), .offload_granted(offload_granted),
		.critical_rank(critical_rank), .critical_valid(critical_valid),
		.optimal_rank(optimal_rank), .optimal_valid(optimal_valid)
	);

endmodule
`default_nettype wire

@@ tb/offload_credit_victim_scheduler_core_tb.sv @@
// testbench: offload credit victim scheduler core, self-checking against an internal predictor
`default_nettype none
module offload_credit_victim_scheduler_core_tb;
	import ocvs_pkg::*;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] rank_first;
		logic [2:0] rank_second;
		logic [30:0] amount;
		logic local_is_victim;
		logic [7:0] blacklist_mask;
		logic [15:0] queued_jobs;
	} sched_req_t;

	typedef struct packed {
		logic [2:0] victim_rank;
		logic offload_granted;
		logic [2:0] critical_rank;
		logic critical_valid;
		logic [2:0] optimal_rank;
		logic optimal_valid;
	} sched_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] op = '0;
	logic [2:0] rank_first = '0;
	logic [2:0] rank_second = '0;
	logic [30:0] amount = '0;
	logic local_is_victim = 1'b0;
	logic [7:0] blacklist_mask = '0;
	logic [15:0] queued_jobs = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] victim_rank;
	logic offload_granted;
	logic [2:0] critical_rank;
	logic critical_valid;
	logic [2:0] optimal_rank;
	logic optimal_valid;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	offload_credit_victim_scheduler_core dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [2:0] m_own;
	logic [30:0] m_thr;
	logic [15:0] m_minq;
	logic m_uen;
	logic [30:0] m_wait [64];
	logic [30:0] m_load [8];
	logic signed [31:0] m_target [8];
	logic signed [31:0] m_credit [8];
	logic [2:0] m_ptr;

	sched_req_t pending_reqs [$];
	sched_res_t expected_results [$];
	int errors = 0;
	int send_idle = 21;
	int recv_idle = 65;
	bit hold_off = 0;

	function automatic logic signed [31:0] sat32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic void predict_update(sched_req_t r, ref sched_res_t res);
		bit waits [8];
		bit awaited [8];
		logic signed [63:0] longest, c, o, s;
		bit opt_ok, crit_ok;
		int opt, crit;
		longest = -1; opt_ok = 0; crit_ok = 0; opt = 0; crit = 0;
		for (int i = 0; i < 8; i++) begin
			awaited[i] = 0;
			waits[i] = 0;
		end
		for (int i = 0; i < 8; i++)
			for (int j = 0; j < 8; j++) begin
				logic signed [63:0] w;
				w = {33'd0, m_wait[i*8+j]};
				if (w > longest && !r.blacklist_mask[i]) begin
					longest = w; opt = i; opt_ok = 1;
				end
				if (m_wait[i*8+j] > m_thr) begin
					awaited[j] = 1; waits[i] = 1;
				end
			end
		for (int i = 0; i < 8; i++)
			if (!crit_ok && !waits[i] && awaited[i]) begin
				crit = i; crit_ok = 1;
			end
		if (crit_ok && m_own == crit && (!opt_ok || crit != opt)) begin
			if (opt_ok && !r.local_is_victim) begin
				c = {33'd0, m_load[crit]};
				for (int i = 0; i < 8; i++) c -= m_target[i];
				o = $signed({33'd0, m_load[opt]}) + m_target[opt];
				s = 2 * m_target[opt] + (c - o);
				m_target[opt] = sat32(s / 2);
			end
		end else if (crit_ok && m_target[crit] > 0)
			m_target[crit] = m_target[crit] - 1;
		for (int i = 0; i < 8; i++)
			if (i != m_own) m_credit[i] = m_target[i];
		res.critical_rank = crit_ok ? crit[2:0] : 3'd0;
		res.critical_valid = crit_ok;
		res.optimal_rank = opt_ok ? opt[2:0] : 3'd0;
		res.optimal_valid = opt_ok;
	endfunction

	function automatic sched_res_t predict_schedule(sched_req_t r);
		sched_res_t res;
		logic [2:0] l, victim;
		bit found;
		res = '0;
		res.victim_rank = m_own;
		case (r.op)
			OP_LOAD: m_load[r.rank_first] = r.amount;
			OP_WAIT: m_wait[{r.rank_first, r.rank_second}] = r.amount;
			OP_UPDATE: if (m_uen) predict_update(r, res);
			OP_EMERG: begin
				if (m_target[r.rank_first] != 32'sh80000000)
					m_target[r.rank_first] = m_target[r.rank_first] - 1;
				m_credit[r.rank_first] = m_target[r.rank_first];
			end
			OP_SELECT: begin
				l = m_ptr; victim = m_own; found = 0;
				for (int i = 0; i < 8; i++)
					if (!found) begin
						if (l != m_own && m_credit[l] > 0) begin
							m_credit[l] = m_credit[l] - 1;
							victim = l; found = 1;
						end else
							m_credit[l] = 0;
						l = l + 3'd1;
					end
				m_ptr = l;
				if (r.queued_jobs < m_minq) victim = m_own;
				res.victim_rank = victim;
				res.offload_granted = victim != m_own;
			end
			default: ;
		endcase
		return res;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!in_valid || !in_stall) begin
			if (in_valid) expected_results.push_back(predict_schedule(
				{op, rank_first, rank_second, amount, local_is_victim, blacklist_mask,
				queued_jobs}));
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
				sched_req_t r;
				r = pending_reqs.pop_front();
				in_valid <= 1'b1;
				{op, rank_first, rank_second, amount, local_is_victim, blacklist_mask,
					queued_jobs} <= r;
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver stall
	always @(posedge clk)
		out_stall <= hold_off || ($urandom_range(99) < recv_idle);

	// monitor
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sched_res_t got, want;
			got = {victim_rank, offload_granted, critical_rank, critical_valid,
				optimal_rank, optimal_valid};
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result %h", $time, got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t mismatch expected %h actual %h", $time, want, got);
				end
			end
		end
	end

	task automatic reg_write(reg_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_OWN: m_own = val[2:0];
			REG_THR: m_thr = val[30:0];
			REG_MINQ: m_minq = val[15:0];
			REG_UEN: m_uen = val[0];
		endcase
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic sched_req_t rand_req(bit structured);
		sched_req_t r;
		r = sched_req_t'(65'({$urandom, $urandom, $urandom}));
		if (structured) begin
			case ($urandom_range(9))
				0, 1: r.op = OP_LOAD;
				2, 3, 4: begin
					r.op = OP_WAIT;
					if ($urandom_range(3) != 0) r.amount = 31'($urandom_range(40000));
				end
				5: r.op = OP_UPDATE;
				6: r.op = OP_EMERG;
				default: r.op = OP_SELECT;
			endcase
			if (r.op == OP_LOAD && $urandom_range(1)) r.amount = 31'($urandom_range(1000));
			if ($urandom_range(1)) r.blacklist_mask &= 8'h0f;
			if ($urandom_range(1)) r.queued_jobs = 16'($urandom_range(20));
		end
		return r;
	endfunction

	task automatic run_random(int n, logic [2:0] own, logic [30:0] thr, logic [15:0] minq);
		reg_write(REG_OWN, 32'(own));
		reg_write(REG_THR, 32'(thr));
		reg_write(REG_MINQ, 32'(minq));
		reg_write(REG_UEN, 32'd1);
		for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req($urandom_range(9) != 0));
		drain();
	endtask

	// stimulus
	initial begin
		sched_req_t r;
		m_own = 0; m_thr = 20000; m_minq = 0; m_uen = 0; m_ptr = 0;
		for (int i = 0; i < 64; i++) m_wait[i] = 0;
		for (int i = 0; i < 8; i++) begin
			m_load[i] = 0; m_target[i] = 0; m_credit[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: update while disabled, bad op codes, extremes
		r = '0; r.op = OP_UPDATE; pending_reqs.push_back(r);
		r = '1; pending_reqs.push_back(r);
		r.op = 3'd5; pending_reqs.push_back(r);
		r.op = 3'd6; pending_reqs.push_back(r);
		r = '0; r.op = OP_SELECT; pending_reqs.push_back(r);
		drain();
		reg_write(REG_UEN, 32'd1);
		// critical rank 0 awaited by rank 2, rank 2 is longest waiter
		r = '0; r.op = OP_LOAD; r.rank_first = 0; r.amount = 31'h7fffffff;
		pending_reqs.push_back(r);
		r.rank_first = 2; r.amount = 5; pending_reqs.push_back(r);
		r = '0; r.op = OP_WAIT; r.rank_first = 2; r.rank_second = 0;
		r.amount = 31'h7fffffff; pending_reqs.push_back(r);
		r = '0; r.op = OP_UPDATE; pending_reqs.push_back(r);
		r.local_is_victim = 1; pending_reqs.push_back(r);
		r.local_is_victim = 0; r.blacklist_mask = 8'hff; pending_reqs.push_back(r);
		r = '0; r.op = OP_SELECT; r.queued_jobs = 16'hffff;
		repeat (3) pending_reqs.push_back(r);
		r = '0; r.op = OP_EMERG; r.rank_first = 2; pending_reqs.push_back(r);
		r.rank_first = 0; pending_reqs.push_back(r);
		drain();
		// own rank not critical: critical target decrements
		reg_write(REG_OWN, 32'd7);
		reg_write(REG_MINQ, 32'hffff);
		r = '0; r.op = OP_UPDATE; pending_reqs.push_back(r);
		r = '0; r.op = OP_SELECT; r.queued_jobs = 16'hfffe; pending_reqs.push_back(r);
		drain();
		// random phases with different settings
		run_random(120, 3'd0, 31'd20000, 16'd0);
		run_random(60, 3'd7, 31'h7fffffff, 16'd10);
		// long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			run_random(60, 3'd5, 31'd0, 16'd5);
		join
		send_idle = 65; recv_idle = 21;
		run_random(150, 3'($urandom), 31'd15000, 16'hffff);
		send_idle = 0; recv_idle = 0;
		run_random(150, 3'd2, 31'd20000, 16'd3);
		reg_write(REG_UEN, 32'd0);
		for (int i = 0; i < 20; i++) pending_reqs.push_back(rand_req(1));
		drain();
		if (errors == 0)
			$display("PASS offload_credit_victim_scheduler_core");
		else
			$display("FAIL offload_credit_victim_scheduler_core");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("FAIL offload_credit_victim_scheduler_core");
		$finish;
	end

endmodule
`default_nettype wire
